/* design/beht_pkg.sv */
// shared types, codes and helpers for the bucketed event hash table
package beht_pkg;

  // operation codes
  localparam logic [2:0] FUNC_FIND  = 3'd0;
  localparam logic [2:0] FUNC_SAVE  = 3'd1;
  localparam logic [2:0] FUNC_ERASE = 3'd2;
  localparam logic [2:0] FUNC_CLEAR = 3'd3;
  localparam logic [2:0] FUNC_NTH   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_MATCH = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_FOUND = 3'd4;
  localparam logic [2:0] ST_NONE  = 3'd5;
  localparam logic [2:0] ST_TRUNC = 3'd6;

  localparam logic [63:0] DELETED_KEY = 64'h0000_0000_0000_00FF;
  localparam logic [5:0]  MAX_MATCHES = 6'd63;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] key;
    logic [7:0]  payload;
    logic [7:0]  index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_out;
    logic [63:0] key_out;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_EVAL, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    M_FIND, M_SAVE, M_FILL, M_ERASE, M_NTH
  } mode_t;

  // reverse the byte order of a key
  function automatic logic [63:0] byte_rev(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  // xor of the eight key bytes
  function automatic logic [7:0] key_hash(input logic [63:0] v);
    logic [7:0] h;
    h = '0;
    for (int i = 0; i < 8; i++) begin
      h = h ^ v[8*i +: 8];
    end
    return h;
  endfunction

endpackage

/* design/bucketed_event_hash_table.sv */
// top level: hash table sequencer around a single slot memory
//
// Slots (64-bit key plus data byte) live in one synchronous memory of
// BUCKETS*SLOTS_PER_BUCKET entries. Find, save and erase walk their probe
// chain and nth walks the memory from its first entry, one slot at a time
// (a read state, then an evaluate-and-write-back state), after an idle state
// that takes the item and before a final state that posts the result. Save
// may walk the chain twice. Clear and the pass that follows reset sweep the
// memory one entry per cycle, during which no item is taken. Find posts
// each match as it is met; a stalled output holds the walk.
module bucketed_event_hash_table #(
  parameter int BUCKETS          = 32,
  parameter int SLOTS_PER_BUCKET = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  beht_pkg::in_t    in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output beht_pkg::out_t   out_item
);
  import beht_pkg::*;

  localparam int TOTAL = BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CW    = $clog2(TOTAL + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
  localparam logic [CW-1:0] LAST_CNT  = CW'(TOTAL - 1);

  typedef logic [AW-1:0] start_tab_t [256];

  // first slot of the home bucket for every hash byte
  function automatic start_tab_t build_start();
    start_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = AW'((i % BUCKETS) * SLOTS_PER_BUCKET);
    end
    return t;
  endfunction

  localparam start_tab_t START_TAB = build_start();

  // slot memory
  logic [71:0] mem [TOTAL];
  logic [71:0] rdata;
  logic [71:0] wdata;
  logic        we, rd_en;

  state_t        state, state_next;
  mode_t         mode, mode_next;
  logic [AW-1:0] addr, addr_next, start_addr, start_addr_next;
  logic [CW-1:0] visited, visited_next;
  logic [5:0]    count, count_next;
  logic [7:0]    left, left_next;
  logic [63:0]   op_key, op_key_next, target, target_next;
  logic [7:0]    op_data, op_data_next;
  logic          clr_report, clr_report_next;
  out_t          fin_item, fin_item_next;
  logic          emit;
  out_t          emit_item;
  logic          can_emit;
  logic          adv;
  logic [2:0]    adv_end;
  logic [63:0]   rkey;
  logic [7:0]    rdat;

  assign rkey     = rdata[71:8];
  assign rdat     = rdata[7:0];
  assign can_emit = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // memory port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      addr       <= '0;
      clr_report <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      addr       <= addr_next;
      clr_report <= clr_report_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode       <= mode_next;
    start_addr <= start_addr_next;
    visited    <= visited_next;
    count      <= count_next;
    left       <= left_next;
    op_key     <= op_key_next;
    target     <= target_next;
    op_data    <= op_data_next;
    fin_item   <= fin_item_next;
    if (emit) begin
      out_item <= emit_item;
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    mode_next       = mode;
    addr_next       = addr;
    start_addr_next = start_addr;
    visited_next    = visited;
    count_next      = count;
    left_next       = left;
    op_key_next     = op_key;
    target_next     = target;
    op_data_next    = op_data;
    clr_report_next = clr_report;
    fin_item_next   = fin_item;
    emit            = 1'b0;
    emit_item       = '0;
    we              = 1'b0;
    wdata           = '0;
    rd_en           = 1'b0;
    adv             = 1'b0;
    adv_end         = ST_DONE;

    case (state)
      S_CLR: begin
        we = 1'b1;
        if (addr == LAST_ADDR) begin
          addr_next     = '0;
          fin_item_next = '{status: ST_DONE, data_out: 8'd0, key_out: 64'd0, last: 1'b1};
          state_next    = clr_report ? S_FIN : S_IDLE;
        end else begin
          addr_next = addr + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_key_next     = in_item.key;
          target_next     = byte_rev(in_item.key);
          op_data_next    = in_item.payload;
          left_next       = in_item.index;
          start_addr_next = START_TAB[key_hash(in_item.key)];
          visited_next    = '0;
          count_next      = '0;
          fin_item_next   = '{status: ST_DONE, data_out: 8'd0, key_out: 64'd0, last: 1'b1};
          case (in_item.func)
            FUNC_FIND: begin
              mode_next  = M_FIND;
              addr_next  = START_TAB[key_hash(in_item.key)];
              state_next = S_RD;
            end
            FUNC_SAVE: begin
              mode_next  = M_SAVE;
              addr_next  = START_TAB[key_hash(in_item.key)];
              state_next = S_RD;
            end
            FUNC_ERASE: begin
              mode_next  = M_ERASE;
              addr_next  = START_TAB[key_hash(in_item.key)];
              state_next = S_RD;
            end
            FUNC_CLEAR: begin
              addr_next       = '0;
              clr_report_next = 1'b1;
              state_next      = S_CLR;
            end
            FUNC_NTH: begin
              mode_next  = M_NTH;
              addr_next  = '0;
              state_next = S_RD;
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end

      S_RD: begin
        rd_en      = 1'b1;
        state_next = S_EVAL;
      end

      S_EVAL: begin
        case (mode)
          M_FIND: begin
            if (rkey == 64'd0) begin
              fin_item_next.status = ST_DONE;
              state_next           = S_FIN;
            end else if (rkey == target) begin
              if (count == MAX_MATCHES) begin
                fin_item_next.status = ST_TRUNC;
                state_next           = S_FIN;
              end else if (can_emit) begin
                emit       = 1'b1;
                emit_item  = '{status: ST_MATCH, data_out: rdat, key_out: 64'd0, last: 1'b0};
                count_next = count + 6'd1;
                adv        = 1'b1;
              end
            end else begin
              adv = 1'b1;
            end
          end
          M_SAVE: begin
            if (rkey == op_key && rdat == op_data) begin
              fin_item_next.status = ST_DUP;
              state_next           = S_FIN;
            end else if (rkey == 64'd0) begin
              mode_next    = M_FILL;
              addr_next    = start_addr;
              visited_next = '0;
              state_next   = S_RD;
            end else begin
              adv = 1'b1;
            end
          end
          M_FILL: begin
            if (rkey[63:8] == 56'd0) begin
              we                   = 1'b1;
              wdata                = {op_key, op_data};
              fin_item_next.status = ST_DONE;
              state_next           = S_FIN;
            end else begin
              adv     = 1'b1;
              adv_end = ST_FULL;
            end
          end
          M_ERASE: begin
            if (rkey == 64'd0) begin
              fin_item_next.status = ST_DONE;
              state_next           = S_FIN;
            end else begin
              if (rkey == op_key) begin
                we    = 1'b1;
                wdata = {DELETED_KEY, 8'd0};
              end
              adv = 1'b1;
            end
          end
          M_NTH: begin
            if (rkey[63:8] != 56'd0 && left == 8'd0) begin
              fin_item_next.status  = ST_FOUND;
              fin_item_next.key_out = byte_rev(rkey);
              state_next            = S_FIN;
            end else begin
              if (rkey[63:8] != 56'd0) begin
                left_next = left - 8'd1;
              end
              adv     = 1'b1;
              adv_end = ST_NONE;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase

        // step to the next slot or close the pass
        if (adv) begin
          if (visited == LAST_CNT) begin
            if (mode == M_SAVE) begin
              mode_next    = M_FILL;
              addr_next    = start_addr;
              visited_next = '0;
              state_next   = S_RD;
            end else begin
              fin_item_next.status = adv_end;
              state_next           = S_FIN;
            end
          end else begin
            visited_next = visited + CW'(1);
            addr_next    = (addr == LAST_ADDR) ? '0 : addr + AW'(1);
            state_next   = S_RD;
          end
        end
      end

      S_FIN: begin
        if (can_emit) begin
          emit            = 1'b1;
          emit_item       = fin_item;
          clr_report_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* verif/bucketed_event_hash_table_test.sv */
// testbench for the bucketed event hash table: predictor, driver, monitor, scoreboard
`timescale 1ns / 100ps

module bucketed_event_hash_table_test;
  import beht_pkg::*;

  localparam int NBUCK = 32;
  localparam int NSLOT = 7;
  localparam int NTOTAL = NBUCK * NSLOT;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;

  bucketed_event_hash_table uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #5 clk = ~clk;

  // predicted table contents
  logic [63:0] tbl_key [NTOTAL];
  logic [7:0] tbl_dat [NTOTAL];

  in_t pending_items[$];
  out_t expected_results[$];
  int errors = 0;
  int driver_busy = 0;
  bit hold_rx = 1'b0;
  bit hold_taken = 1'b0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  bit in_ready_seen = 1'b0;
  bit gap_mode = 1'b1;
  // key pool so that random items hit stored keys
  logic [63:0] key_pool[$];

  function automatic logic [63:0] swap_bytes(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = v[8*(7-i) +: 8];
    return r;
  endfunction

  function automatic int home_of(input logic [63:0] k);
    logic [7:0] h;
    h = '0;
    for (int i = 0; i < 8; i++) h ^= k[8*i +: 8];
    return int'(h) % NBUCK;
  endfunction

  function automatic void push_result(input logic [2:0] st, input logic [7:0] d,
                                      input logic [63:0] k, input logic l);
    out_t r;
    r.status = st; r.data_out = d; r.key_out = k; r.last = l;
    expected_results.push_back(r);
  endfunction

  // compute the results of one accepted item and update the table
  function automatic void predict_table_op(input in_t it);
    int h, idx, cnt;
    bit stop, trunc, done;
    logic [63:0] tgt;
    int left;
    h = home_of(it.key);
    stop = 0; trunc = 0; cnt = 0; done = 0;
    case (it.func)
      FUNC_FIND: begin
        tgt = swap_bytes(it.key);
        for (int n = 0; n < NBUCK && !stop; n++)
          for (int s = 0; s < NSLOT && !stop; s++) begin
            idx = ((h + n) % NBUCK) * NSLOT + s;
            if (tbl_key[idx] == 64'd0) stop = 1;
            else if (tbl_key[idx] == tgt) begin
              if (cnt >= 63) begin trunc = 1; stop = 1; end
              else begin push_result(ST_MATCH, tbl_dat[idx], '0, 1'b0); cnt++; end
            end
          end
        push_result(trunc ? ST_TRUNC : ST_DONE, '0, '0, 1'b1);
      end
      FUNC_SAVE: begin
        for (int n = 0; n < NBUCK && !stop && !done; n++)
          for (int s = 0; s < NSLOT && !stop && !done; s++) begin
            idx = ((h + n) % NBUCK) * NSLOT + s;
            if (tbl_key[idx] == it.key && tbl_dat[idx] == it.payload) done = 1;
            else if (tbl_key[idx] == 64'd0) stop = 1;
          end
        if (done) push_result(ST_DUP, '0, '0, 1'b1);
        else begin
          for (int n = 0; n < NBUCK && !done; n++)
            for (int s = 0; s < NSLOT && !done; s++) begin
              idx = ((h + n) % NBUCK) * NSLOT + s;
              if (tbl_key[idx][63:8] == 56'd0) begin
                tbl_key[idx] = it.key; tbl_dat[idx] = it.payload; done = 1;
              end
            end
          push_result(done ? ST_DONE : ST_FULL, '0, '0, 1'b1);
        end
      end
      FUNC_ERASE: begin
        for (int n = 0; n < NBUCK && !stop; n++)
          for (int s = 0; s < NSLOT && !stop; s++) begin
            idx = ((h + n) % NBUCK) * NSLOT + s;
            if (tbl_key[idx] == 64'd0) stop = 1;
            else if (tbl_key[idx] == it.key) begin
              tbl_key[idx] = DELETED_KEY; tbl_dat[idx] = '0;
            end
          end
        push_result(ST_DONE, '0, '0, 1'b1);
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < NTOTAL; i++) begin tbl_key[i] = '0; tbl_dat[i] = '0; end
        push_result(ST_DONE, '0, '0, 1'b1);
      end
      FUNC_NTH: begin
        left = it.index;
        for (int i = 0; i < NTOTAL && !done; i++)
          if (tbl_key[i][63:8] != 56'd0) begin
            if (left == 0) begin
              push_result(ST_FOUND, '0, swap_bytes(tbl_key[i]), 1'b1); done = 1;
            end else left--;
          end
        if (!done) push_result(ST_NONE, '0, '0, 1'b1);
      end
      default: push_result(ST_DONE, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic in_t make_item(input logic [2:0] f, input logic [63:0] k,
                                    input logic [7:0] p, input logic [7:0] ix);
    in_t it;
    it.func = f; it.key = k; it.payload = p; it.index = ix;
    return it;
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // key whose home bucket is the given one, with byte 7 nonzero
  function automatic logic [63:0] key_in_bucket(input int b);
    logic [63:0] k;
    k = {$urandom, $urandom} | 64'h0100_0000_0000_0000;
    k[7:0] = '0;
    k[7:0] = 8'(b) ^ 8'(home_of(k));
    return k;
  endfunction

  function automatic logic [63:0] pool_key();
    if (key_pool.size() == 0 || $urandom_range(0, 3) == 0) begin
      key_pool.push_back($urandom_range(0, 1) ? rand_key() : key_in_bucket($urandom_range(0, 3)));
      if (key_pool.size() > 24) void'(key_pool.pop_front());
      return key_pool[$];
    end
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  // driver: offers queued items, with random gaps when gap_mode is set
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_items.size() > 0 && driver_busy == 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          driver_busy <= gap_mode ? $urandom_range(0, 15) : 0;
        end else begin
          in_valid <= 1'b0;
          if (driver_busy > 0) driver_busy <= driver_busy - 1;
        end
      end
    end
  end

  // monitor: captures accepted items and results at the rising edge
  always @(posedge clk) begin
    in_ready_seen <= !rst && in_valid && in_ready;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid && in_ready) begin
        predict_table_op(in_item);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result status=%0d", out_item.status);
          errors++;
        end else begin
          out_t e;
          e = expected_results.pop_front();
          if (e.status !== out_item.status) begin
            $error("status expected %0d actual %0d", e.status, out_item.status); errors++;
          end
          if (e.data_out !== out_item.data_out) begin
            $error("data_out expected %0h actual %0h", e.data_out, out_item.data_out); errors++;
          end
          if (e.key_out !== out_item.key_out) begin
            $error("key_out expected %0h actual %0h", e.key_out, out_item.key_out); errors++;
          end
          if (e.last !== out_item.last) begin
            $error("last expected %0d actual %0d", e.last, out_item.last); errors++;
          end
        end
      end
      if (idle_cycles > STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls when gap_mode is set, plus one long hold-off
  int rx_wait = 0;
  always @(negedge clk) begin
    if (hold_rx && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (out_ready && out_valid) begin
      rx_wait = gap_mode ? $urandom_range(0, 15) : 0;
      out_ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= (rx_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic add_save_find(input int n);
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      k = pool_key();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pending_items.push_back(make_item(FUNC_SAVE, k, 8'($urandom), 8'($urandom)));
        4, 5, 6: pending_items.push_back(make_item(FUNC_FIND, swap_bytes(k), 8'($urandom),
                                                   8'($urandom)));
        7: pending_items.push_back(make_item(FUNC_ERASE, k, 8'($urandom), 8'($urandom)));
        8: pending_items.push_back(make_item(FUNC_NTH, rand_key(), 8'($urandom),
                                             8'($urandom_range(0, 40))));
        default: pending_items.push_back(make_item(3'($urandom_range(0, 7)), rand_key(),
                                                   8'($urandom), 8'($urandom)));
      endcase
    end
  endtask

  logic [63:0] kdup;
  initial begin
    for (int i = 0; i < NTOTAL; i++) begin tbl_key[i] = '0; tbl_dat[i] = '0; end
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed: extremes, every operation, special cases
    kdup = 64'h0102_0304_0506_0708;
    pending_items.push_back(make_item(FUNC_NTH, '0, '0, 8'd0));
    pending_items.push_back(make_item(FUNC_FIND, '0, '0, '0));
    pending_items.push_back(make_item(FUNC_SAVE, '0, 8'd0, '0));
    pending_items.push_back(make_item(FUNC_SAVE, '0, 8'hFF, '0));
    pending_items.push_back(make_item(FUNC_SAVE, '1, 8'hFF, 8'hFF));
    pending_items.push_back(make_item(FUNC_SAVE, kdup, 8'h11, '0));
    pending_items.push_back(make_item(FUNC_SAVE, kdup, 8'h11, '0));
    pending_items.push_back(make_item(FUNC_SAVE, kdup, 8'h22, '0));
    pending_items.push_back(make_item(FUNC_FIND, swap_bytes(kdup), '0, '0));
    pending_items.push_back(make_item(FUNC_FIND, '1, '0, '0));
    pending_items.push_back(make_item(FUNC_NTH, '0, '0, 8'd1));
    pending_items.push_back(make_item(FUNC_NTH, '0, '0, 8'hFF));
    pending_items.push_back(make_item(FUNC_ERASE, kdup, '0, '0));
    pending_items.push_back(make_item(FUNC_SAVE, DELETED_KEY, 8'h5, '0));
    pending_items.push_back(make_item(FUNC_FIND, swap_bytes(kdup), '0, '0));
    pending_items.push_back(make_item(FUNC_SAVE, kdup, 8'h33, '0));
    pending_items.push_back(make_item(3'd5, '1, '1, '1));
    pending_items.push_back(make_item(3'd6, '0, '0, '0));
    pending_items.push_back(make_item(3'd7, '1, '0, '1));
    pending_items.push_back(make_item(FUNC_CLEAR, '0, '0, '0));
    pending_items.push_back(make_item(FUNC_NTH, '0, '0, 8'd0));
    wait_drained();

    // fill the table with one key to reach truncation, then with random keys to a full table
    gap_mode = 1'b0;
    for (int i = 0; i < 70; i++)
      pending_items.push_back(make_item(FUNC_SAVE, kdup, 8'(i), '0));
    pending_items.push_back(make_item(FUNC_FIND, swap_bytes(kdup), '0, '0));
    wait_drained();
    hold_rx = 1'b1;
    for (int i = 0; i < 160; i++)
      pending_items.push_back(make_item(FUNC_SAVE, rand_key(), 8'($urandom), '0));
    @(posedge clk);
    while (!hold_taken || hold_cnt > 0) @(posedge clk);
    wait_drained();
    pending_items.push_back(make_item(FUNC_SAVE, rand_key(), 8'd1, '0));
    pending_items.push_back(make_item(FUNC_NTH, '0, '0, 8'd223));
    pending_items.push_back(make_item(FUNC_FIND, '0, '0, '0));
    pending_items.push_back(make_item(FUNC_ERASE, kdup, '0, '0));
    pending_items.push_back(make_item(FUNC_CLEAR, '0, '0, '0));
    wait_drained();

    // random phases with and without idling
    gap_mode = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      gap_mode = (ph != 2);
      add_save_find(40);
      pending_items.push_back(make_item(FUNC_CLEAR, '0, '0, '0));
      wait_drained();
    end
    add_save_find(60);
    wait_drained();

    repeat (600) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
